### sv/tdsm_pkg.sv
// ============================================================================
// tdsm_pkg - shared types and constants of the two-deck tone sequencer mixer
// Field widths, timing constants, command encoding and the knob quantizers.
// ============================================================================
`default_nettype none

package tdsm_pkg;

    // default storage depth of each note track
    localparam int TRACK_DEPTH_DEF = 256;

    // tick counter timing
    localparam int POLL_PERIOD   = 2000;
    localparam int SAMPLE_PERIOD = 100;

    // field widths
    localparam int TICK_W   = 11;
    localparam int PHASE_W  = $clog2(SAMPLE_PERIOD);
    localparam int NOTE_W   = 8;
    localparam int POS_W    = 17;
    localparam int LEN_W    = 9;
    localparam int KNOB_W   = 10;
    localparam int TONE_W   = 16;
    localparam int DUR_W    = 16;
    localparam int SPEED_W  = 4;
    localparam int WEIGHT_W = 11;
    localparam int VOL_W    = 6;
    localparam int MIX_W    = 28;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [TICK_W-1:0]   POLL_COUNT      = TICK_W'(POLL_PERIOD);
    localparam logic [PHASE_W-1:0]  PHASE_LAST      = PHASE_W'(SAMPLE_PERIOD - 1);
    localparam logic [PHASE_W-1:0]  PHASE_VOLUME    = PHASE_W'(80);
    localparam logic [PHASE_W-1:0]  PHASE_FADE      = PHASE_W'(60);
    localparam logic [PHASE_W-1:0]  PHASE_SPEED_ONE = PHASE_W'(40);
    localparam logic [PHASE_W-1:0]  PHASE_SPEED_TWO = PHASE_W'(20);
    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT     = WEIGHT_W'(1024);

    // speed knob edges, entry 0 is the lowest
    localparam logic [8:0][KNOB_W-1:0] SPEED_EDGES = {
        10'd922, 10'd819, 10'd717, 10'd615, 10'd512,
        10'd410, 10'd308, 10'd205, 10'd103
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic {
        REG_DECK_ONE_LENGTH = 1'b0,
        REG_DECK_TWO_LENGTH = 1'b1
    } t_reg_index;

    typedef enum logic {
        CMD_PLAY = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd_kind;

    // one queue entry: a note load or a classified playback tick
    typedef struct packed {
        t_cmd_kind            kind;
        logic                 load_deck;
        logic [NOTE_W-1:0]    load_index;
        logic [TONE_W-1:0]    load_tone;
        logic [DUR_W-1:0]     load_duration;
        logic                 play_one;
        logic                 play_two;
        logic [SPEED_W-1:0]   speed_one;
        logic [SPEED_W-1:0]   speed_two;
        logic [WEIGHT_W-1:0]  fade_weight;
        logic [VOL_W-1:0]     volume;
    } t_cmd;

    function automatic logic [VOL_W-1:0] quant_volume(input logic [KNOB_W-1:0] s);
        logic [VOL_W-1:0] q;
        if (s < 10'd171)      q = 6'd32;
        else if (s < 10'd341) q = 6'd16;
        else if (s < 10'd512) q = 6'd8;
        else if (s < 10'd683) q = 6'd4;
        else if (s < 10'd853) q = 6'd2;
        else                  q = 6'd1;
        return q;
    endfunction

    function automatic logic [SPEED_W-1:0] quant_speed(input logic [KNOB_W-1:0] s);
        logic [SPEED_W-1:0] q;
        q = SPEED_W'(10);
        for (int i = 8; i >= 0; i--) begin
            if (s < SPEED_EDGES[i]) q = SPEED_W'(i + 1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### sv/tdsm_if.sv
// ============================================================================
// tdsm_if - item and result channels of the tone sequencer mixer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface tdsm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic                               load_deck;
    logic [tdsm_pkg::NOTE_W-1:0]        load_index;
    logic [tdsm_pkg::TONE_W-1:0]        load_tone;
    logic [tdsm_pkg::DUR_W-1:0]         load_duration;
    logic [tdsm_pkg::KNOB_W-1:0]        volume_knob;
    logic [tdsm_pkg::KNOB_W-1:0]        speed_one_knob;
    logic [tdsm_pkg::KNOB_W-1:0]        speed_two_knob;
    logic [tdsm_pkg::KNOB_W-1:0]        fade_knob;
    logic                               play_one_button;
    logic                               play_two_button;
    logic                               escape_button;

    modport source (
        output valid, op, load_deck, load_index, load_tone, load_duration,
               volume_knob, speed_one_knob, speed_two_knob, fade_knob,
               play_one_button, play_two_button, escape_button,
        input  ready
    );

    modport sink (
        input  valid, op, load_deck, load_index, load_tone, load_duration,
               volume_knob, speed_one_knob, speed_two_knob, fade_knob,
               play_one_button, play_two_button, escape_button,
        output ready
    );
endinterface

interface tdsm_out_if;
    logic                           valid;
    logic                           ready;
    logic [tdsm_pkg::TONE_W-1:0]    tone_out;
    logic [tdsm_pkg::VOL_W-1:0]     volume_out;

    modport source (
        output valid, tone_out, volume_out,
        input  ready
    );

    modport sink (
        input  valid, tone_out, volume_out,
        output ready
    );
endinterface

`default_nettype wire

### sv/tdsm_front.sv
// ============================================================================
// tdsm_front - item intake and tick classification
// Runs the tick counter, button polling and knob sampling, and turns each
// accepted item into a load or play command for the queue.
// ============================================================================
`default_nettype none

module tdsm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tdsm_in_if.sink             i_item,
    input  wire logic           i_push_ready,
    output logic                o_push_valid,
    output tdsm_pkg::t_cmd      o_push_cmd
);

    logic [tdsm_pkg::TICK_W-1:0]   r_tick_count, n_tick_count;
    logic [tdsm_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic                          r_halted;
    logic                          r_play_one, n_play_one;
    logic                          r_play_two, n_play_two;
    logic [tdsm_pkg::VOL_W-1:0]    r_volume, n_volume;
    logic [tdsm_pkg::WEIGHT_W-1:0] r_fade, n_fade;
    logic [tdsm_pkg::SPEED_W-1:0]  r_speed_one, n_speed_one;
    logic [tdsm_pkg::SPEED_W-1:0]  r_speed_two, n_speed_two;

    logic                          is_load;
    logic                          poll;
    logic                          escape;
    logic                          tick_live;
    logic [tdsm_pkg::TICK_W-1:0]   tick_base;
    logic [tdsm_pkg::PHASE_W-1:0]  phase_base;

    assign i_item.ready = i_push_ready;

    always_comb begin
        is_load   = (i_item.op == tdsm_pkg::OP_LOAD);
        poll      = (r_tick_count == tdsm_pkg::POLL_COUNT);
        escape    = poll && i_item.escape_button;
        tick_live = i_item.valid && i_push_ready && !is_load && !r_halted;

        n_play_one = r_play_one ^ (poll && i_item.play_one_button);
        n_play_two = r_play_two ^ (poll && i_item.play_two_button);
        tick_base  = poll ? '0 : r_tick_count;
        phase_base = poll ? '0 : r_phase;

        n_volume = r_volume;
        if (phase_base == tdsm_pkg::PHASE_VOLUME) begin
            n_volume = tdsm_pkg::quant_volume(i_item.volume_knob);
        end

        n_fade = r_fade;
        if (phase_base == tdsm_pkg::PHASE_FADE) begin
            // a stopped deck hands full weight to the other one
            if (!n_play_one) begin
                n_fade = '0;
            end else if (!n_play_two) begin
                n_fade = tdsm_pkg::FULL_WEIGHT;
            end else begin
                n_fade = tdsm_pkg::FULL_WEIGHT - {1'b0, i_item.fade_knob};
            end
        end

        n_speed_one = r_speed_one;
        if (phase_base == tdsm_pkg::PHASE_SPEED_ONE) begin
            n_speed_one = tdsm_pkg::quant_speed(i_item.speed_one_knob);
        end
        n_speed_two = r_speed_two;
        if (phase_base == tdsm_pkg::PHASE_SPEED_TWO) begin
            n_speed_two = tdsm_pkg::quant_speed(i_item.speed_two_knob);
        end

        n_tick_count = tick_base + 1'b1;
        n_phase      = (phase_base == tdsm_pkg::PHASE_LAST) ? '0 : phase_base + 1'b1;

        // halted ticks and the escape tick are dropped here
        o_push_valid = i_item.valid && (is_load || (!r_halted && !escape));

        o_push_cmd.kind          = is_load ? tdsm_pkg::CMD_LOAD : tdsm_pkg::CMD_PLAY;
        o_push_cmd.load_deck     = i_item.load_deck;
        o_push_cmd.load_index    = i_item.load_index;
        o_push_cmd.load_tone     = i_item.load_tone;
        o_push_cmd.load_duration = i_item.load_duration;
        o_push_cmd.play_one      = n_play_one;
        o_push_cmd.play_two      = n_play_two;
        o_push_cmd.speed_one     = n_speed_one;
        o_push_cmd.speed_two     = n_speed_two;
        o_push_cmd.fade_weight   = n_fade;
        o_push_cmd.volume        = n_volume;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_phase      <= '0;
            r_halted     <= 1'b0;
            r_play_one   <= 1'b1;
            r_play_two   <= 1'b1;
            r_volume     <= '0;
            r_fade       <= '0;
            r_speed_one  <= '0;
            r_speed_two  <= '0;
        end else if (tick_live) begin
            if (escape) begin
                r_halted <= 1'b1;
            end else begin
                r_tick_count <= n_tick_count;
                r_phase      <= n_phase;
                r_play_one   <= n_play_one;
                r_play_two   <= n_play_two;
                r_volume     <= n_volume;
                r_fade       <= n_fade;
                r_speed_one  <= n_speed_one;
                r_speed_two  <= n_speed_two;
            end
        end
    end

endmodule

`default_nettype wire

### sv/tdsm_queue.sv
// ============================================================================
// tdsm_queue - command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module tdsm_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push_valid,
    output logic                    o_push_ready,
    input  tdsm_pkg::t_cmd          i_push_cmd,
    output logic                    o_head_valid,
    output tdsm_pkg::t_cmd          o_head_cmd,
    input  wire logic               i_pop
);

    localparam int PTR_W = $clog2(tdsm_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tdsm_pkg::QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(tdsm_pkg::QUEUE_DEPTH);

    tdsm_pkg::t_cmd     r_slots [tdsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_slots[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/tdsm_back.sv
// ============================================================================
// tdsm_back - track stores, deck playback and crossfade mixer
// Executes queued loads and play commands; keeps the current note entry of
// each deck in a cache register and refills it from the store on a note move.
// ============================================================================
`default_nettype none

module tdsm_back #(
    parameter int TRACK_DEPTH = tdsm_pkg::TRACK_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [tdsm_pkg::LEN_W-1:0] i_deck_one_length,
    input  wire logic [tdsm_pkg::LEN_W-1:0] i_deck_two_length,
    input  wire logic                       i_head_valid,
    input  tdsm_pkg::t_cmd                  i_head_cmd,
    output logic                            o_pop,
    tdsm_out_if.source                      o_result
);

    localparam int AW      = $clog2(TRACK_DEPTH);
    localparam int ENTRY_W = tdsm_pkg::TONE_W + tdsm_pkg::DUR_W;
    localparam int PROD_W  = tdsm_pkg::TONE_W + tdsm_pkg::WEIGHT_W;

    // track stores, tone in the upper half of each entry
    logic [ENTRY_W-1:0] r_store_one [TRACK_DEPTH];
    logic [ENTRY_W-1:0] r_store_two [TRACK_DEPTH];
    logic [ENTRY_W-1:0] r_rdata [2];

    logic [tdsm_pkg::NOTE_W-1:0]  r_note [2];
    logic [tdsm_pkg::POS_W-1:0]   r_pos [2];
    logic [tdsm_pkg::TONE_W-1:0]  r_cache_tone [2];
    logic [tdsm_pkg::DUR_W-1:0]   r_cache_dur [2];
    logic                         r_cache_valid [2];
    logic                         r_fill;
    logic                         r_out_valid;
    logic [tdsm_pkg::TONE_W-1:0]  r_tone_out;
    logic [tdsm_pkg::VOL_W-1:0]   r_volume_out;

    logic                         head_play;
    logic                         head_load;
    logic                         fetch;
    logic                         out_free;
    logic                         load_in_range;
    logic [AW-1:0]                load_addr;
    logic [ENTRY_W-1:0]           load_entry;
    logic                         store_we [2];
    logic                         load_hit [2];
    logic [AW-1:0]                note_addr [2];
    logic                         note_in_range [2];
    logic                         miss [2];
    logic [tdsm_pkg::TONE_W-1:0]  eff_tone [2];
    logic [tdsm_pkg::DUR_W-1:0]   eff_dur [2];
    logic                         playing [2];
    logic [tdsm_pkg::SPEED_W-1:0] speed [2];
    logic [tdsm_pkg::LEN_W-1:0]   length [2];
    logic [tdsm_pkg::POS_W-1:0]   new_pos [2];
    logic                         advance [2];
    logic [tdsm_pkg::LEN_W-1:0]   next_wide [2];
    logic [tdsm_pkg::NOTE_W-1:0]  next_note [2];
    logic [PROD_W-1:0]            term [2];
    logic [tdsm_pkg::WEIGHT_W-1:0] weight_two;
    logic [tdsm_pkg::MIX_W-1:0]   mix;

    always_comb begin
        head_play = i_head_valid && (i_head_cmd.kind == tdsm_pkg::CMD_PLAY);
        head_load = i_head_valid && (i_head_cmd.kind == tdsm_pkg::CMD_LOAD);

        load_in_range = (32'(i_head_cmd.load_index) < 32'(TRACK_DEPTH));
        load_addr     = AW'(i_head_cmd.load_index);
        load_entry    = {i_head_cmd.load_tone, i_head_cmd.load_duration};

        playing[0] = i_head_cmd.play_one;
        playing[1] = i_head_cmd.play_two;
        speed[0]   = i_head_cmd.speed_one;
        speed[1]   = i_head_cmd.speed_two;
        length[0]  = i_deck_one_length;
        length[1]  = i_deck_two_length;
        weight_two = tdsm_pkg::FULL_WEIGHT - i_head_cmd.fade_weight;

        for (int d = 0; d < 2; d++) begin
            note_addr[d]     = AW'(r_note[d]);
            note_in_range[d] = (32'(r_note[d]) < 32'(TRACK_DEPTH));
            miss[d]          = note_in_range[d] && !r_cache_valid[d];
            store_we[d]      = head_load && load_in_range && (i_head_cmd.load_deck == d[0]);
            load_hit[d]      = head_load && (i_head_cmd.load_deck == d[0])
                               && (i_head_cmd.load_index == r_note[d]);

            // slots beyond the store read as a zero entry
            if (!note_in_range[d]) begin
                eff_tone[d] = '0;
                eff_dur[d]  = '0;
            end else if (r_cache_valid[d]) begin
                eff_tone[d] = r_cache_tone[d];
                eff_dur[d]  = r_cache_dur[d];
            end else begin
                eff_tone[d] = r_rdata[d][ENTRY_W-1:tdsm_pkg::DUR_W];
                eff_dur[d]  = r_rdata[d][tdsm_pkg::DUR_W-1:0];
            end

            new_pos[d]   = r_pos[d] + tdsm_pkg::POS_W'(speed[d]);
            advance[d]   = (new_pos[d] > tdsm_pkg::POS_W'(eff_dur[d]));
            next_wide[d] = {1'b0, r_note[d]} + 1'b1;
            if (next_wide[d] >= length[d]) begin
                next_wide[d] = '0;
            end
            next_note[d] = next_wide[d][tdsm_pkg::NOTE_W-1:0];
        end

        term[0] = playing[0] ? PROD_W'(eff_tone[0]) * PROD_W'(i_head_cmd.fade_weight) : '0;
        term[1] = playing[1] ? PROD_W'(eff_tone[1]) * PROD_W'(weight_two) : '0;
        mix     = tdsm_pkg::MIX_W'(term[0]) + tdsm_pkg::MIX_W'(term[1]);

        // a missing entry is read into r_rdata first; the command waits for it
        fetch    = head_play && !r_fill && (miss[0] || miss[1]);
        out_free = !r_out_valid || o_result.ready;
        o_pop    = head_load || (head_play && !fetch && out_free);
    end

    always_ff @(posedge i_clk) begin
        if (store_we[0]) begin
            r_store_one[load_addr] <= load_entry;
        end
        if (fetch) begin
            r_rdata[0] <= r_store_one[note_addr[0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we[1]) begin
            r_store_two[load_addr] <= load_entry;
        end
        if (fetch) begin
            r_rdata[1] <= r_store_two[note_addr[1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < 2; d++) begin
                r_note[d]        <= '0;
                r_pos[d]         <= '0;
                r_cache_valid[d] <= 1'b0;
            end
        end else begin
            r_fill <= fetch;
            if (o_pop && head_play) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            for (int d = 0; d < 2; d++) begin
                if (load_hit[d]) begin
                    r_cache_valid[d] <= 1'b1;
                end else if (o_pop && head_play && playing[d] && advance[d]) begin
                    r_note[d]        <= next_note[d];
                    r_pos[d]         <= '0;
                    r_cache_valid[d] <= (next_note[d] == r_note[d]);
                end else begin
                    if (o_pop && head_play && playing[d]) begin
                        r_pos[d] <= new_pos[d];
                    end
                    if (r_fill) begin
                        r_cache_valid[d] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < 2; d++) begin
            if (load_hit[d]) begin
                r_cache_tone[d] <= i_head_cmd.load_tone;
                r_cache_dur[d]  <= i_head_cmd.load_duration;
            end else if (r_fill) begin
                r_cache_tone[d] <= eff_tone[d];
                r_cache_dur[d]  <= eff_dur[d];
            end
        end
        if (o_pop && head_play) begin
            r_tone_out   <= mix[tdsm_pkg::TONE_W+9:10];
            r_volume_out <= i_head_cmd.volume;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.tone_out   = r_tone_out;
    assign o_result.volume_out = r_volume_out;

endmodule

`default_nettype wire

### sv/two_deck_tone_sequencer_mixer.sv
// ============================================================================
// two_deck_tone_sequencer_mixer - two-track tone sequencer with crossfade
// Top level: configuration registers, front, command queue and back.
// ============================================================================
// usage
//   i_item carries one item per transfer: op selects a note load (track,
//   slot, tone, duration) or a playback tick (four knob samples, three
//   buttons). o_result carries one tone/volume pair for every tick that
//   plays; loads, ticks after escape and the escape tick itself give none.
//   deck_one_length / deck_two_length must be written over the apb port
//   (byte address 0 and 4) by the user only when idle; the block won't check.
// pipeline and throughput
//   a tick is registered in the queue, and its result in the output register.
//   one item per cycle while o_result is not stalled; a tick that follows
//   a note change of either deck (and the first tick after reset) waits
//   for the read of the new note entry from the track store.
// reset
//   i_rst_n is synchronous: counters, deck positions and notes clear, both
//   decks play, lengths go to 1. track stores keep whatever they hold and
//   must be loaded before the slots are played; no clearing pass.
// stall
//   a stalled result holds in the output register; up to two more items
//   wait in the queue, then i_item.ready drops until o_result moves again.
// ============================================================================
`default_nettype none

module two_deck_tone_sequencer_mixer #(
    parameter int TRACK_DEPTH = tdsm_pkg::TRACK_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tdsm_in_if.sink                             i_item,
    tdsm_out_if.source                          o_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tdsm_pkg::APB_AW-1:0]    paddr,
    input  wire logic [tdsm_pkg::APB_DW-1:0]    pwdata,
    output logic      [tdsm_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);

    // track lengths, wrap point of each deck's note index
    logic [tdsm_pkg::LEN_W-1:0] r_deck_one_length;
    logic [tdsm_pkg::LEN_W-1:0] r_deck_two_length;
    tdsm_pkg::t_reg_index       reg_sel;

    // front to queue
    logic                       push_valid;
    logic                       push_ready;
    tdsm_pkg::t_cmd             push_cmd;

    // queue to back
    logic                       head_valid;
    tdsm_pkg::t_cmd             head_cmd;
    logic                       pop;

    // apb: no wait states, register picked by address bit 2
    assign pready  = 1'b1;
    assign reg_sel = tdsm_pkg::t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deck_one_length <= tdsm_pkg::LEN_W'(1);
            r_deck_two_length <= tdsm_pkg::LEN_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                tdsm_pkg::REG_DECK_ONE_LENGTH: begin
                    r_deck_one_length <= pwdata[tdsm_pkg::LEN_W-1:0];
                end
                tdsm_pkg::REG_DECK_TWO_LENGTH: begin
                    r_deck_two_length <= pwdata[tdsm_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tdsm_pkg::REG_DECK_ONE_LENGTH: begin
                prdata = tdsm_pkg::APB_DW'(r_deck_one_length);
            end
            tdsm_pkg::REG_DECK_TWO_LENGTH: begin
                prdata = tdsm_pkg::APB_DW'(r_deck_two_length);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // front: tick counter, button polling, knob sampling
    tdsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    // decouples intake from playback
    tdsm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd),
        .i_pop        (pop)
    );

    // back: track stores, deck advance, crossfade, output register
    tdsm_back #(
        .TRACK_DEPTH (TRACK_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_deck_one_length (r_deck_one_length),
        .i_deck_two_length (r_deck_two_length),
        .i_head_valid      (head_valid),
        .i_head_cmd        (head_cmd),
        .o_pop             (pop),
        .o_result          (o_result)
    );

endmodule

`default_nettype wire

### sv/tdsm_checker.sv
// ============================================================================
// tdsm_checker - port-level checks of the tone sequencer mixer
// Watches the result channel and the configuration port.
// ============================================================================
`default_nettype none

module tdsm_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [tdsm_pkg::TONE_W-1:0]    i_tone_out,
    input  wire logic [tdsm_pkg::VOL_W-1:0]     i_volume_out,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [tdsm_pkg::APB_AW-1:0]    i_paddr,
    input  wire logic [tdsm_pkg::APB_DW-1:0]    i_pwdata,
    input  wire logic [tdsm_pkg::APB_DW-1:0]    i_prdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_tone_out) && $stable(i_volume_out))
        else $error("result payload changed while stalled");

    // volume is zero or a power of two up to 32
    a_volume_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_volume_out))
        else $error("volume out of its code set");

    // a written deck one track length reads back on the next cycle
    a_len_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_pready && !i_paddr[2])
        ##1 (i_psel && !i_pwrite && !i_paddr[2])
        |-> i_prdata == {23'd0, $past(i_pwdata[8:0])})
        else $error("track length readback mismatch");

endmodule

bind two_deck_tone_sequencer_mixer tdsm_checker u_tdsm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_tone_out   (o_result.tone_out),
    .i_volume_out (o_result.volume_out),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_pready     (pready),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata)
);

`default_nettype wire

### verif/tdsm_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tdsm_tb_pkg - item types and scoreboard for the tone sequencer mixer bench
// Holds the bench's own model of both decks, the tick counter and the knob
// quantizers, and checks every tone/volume result against it in order.
// ============================================================================

package tdsm_tb_pkg;

    import tdsm_pkg::*;

    // knob thresholds, ascending
    localparam int VOLUME_STEPS [5] = '{171, 341, 512, 683, 853};
    localparam int RATE_STEPS [9]   = '{103, 205, 308, 410, 512, 615, 717, 819, 922};

    typedef struct packed {
        t_op                 op;
        logic                load_deck;
        logic [NOTE_W-1:0]   load_index;
        logic [TONE_W-1:0]   load_tone;
        logic [DUR_W-1:0]    load_duration;
        logic [KNOB_W-1:0]   volume_knob;
        logic [KNOB_W-1:0]   speed_one_knob;
        logic [KNOB_W-1:0]   speed_two_knob;
        logic [KNOB_W-1:0]   fade_knob;
        logic                play_one_button;
        logic                play_two_button;
        logic                escape_button;
    } mixer_item_t;

    typedef struct packed {
        logic [TONE_W-1:0]   tone;
        logic [VOL_W-1:0]    volume;
    } mix_out_t;

    class mixer_scoreboard;
        logic [TONE_W-1:0]   track_tone [2][TRACK_DEPTH_DEF];
        logic [DUR_W-1:0]    track_dur [2][TRACK_DEPTH_DEF];
        logic [LEN_W-1:0]    deck_len [2];
        logic [TICK_W-1:0]   tick_count;
        logic                playing [2];
        logic [NOTE_W-1:0]   note [2];
        logic [POS_W-1:0]    position [2];
        logic [SPEED_W-1:0]  speed [2];
        logic [VOL_W-1:0]    volume_level;
        logic [WEIGHT_W-1:0] weight;
        logic                halted;
        mix_out_t            pending_mixes [$];
        int unsigned         errors;
        int unsigned         results_seen;

        function new();
            for (int d = 0; d < 2; d++) begin
                deck_len[d] = LEN_W'(1);
                playing[d]  = 1'b1;
                note[d]     = '0;
                position[d] = '0;
                speed[d]    = '0;
            end
            tick_count   = '0;
            volume_level = '0;
            weight       = '0;
            halted       = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_length(t_reg_index r, logic [LEN_W-1:0] v);
            deck_len[r] = v;
        endfunction

        function int unsigned pending();
            return pending_mixes.size();
        endfunction

        function logic [VOL_W-1:0] volume_divisor(logic [KNOB_W-1:0] s);
            logic [VOL_W-1:0] lvl;
            lvl = VOL_W'(32);
            foreach (VOLUME_STEPS[i])
                if (s >= VOLUME_STEPS[i]) lvl = lvl >> 1;
            return lvl;
        endfunction

        function logic [SPEED_W-1:0] deck_rate(logic [KNOB_W-1:0] s);
            logic [SPEED_W-1:0] q;
            q = SPEED_W'(1);
            foreach (RATE_STEPS[i])
                if (s >= RATE_STEPS[i]) q = q + 1'b1;
            return q;
        endfunction

        // current note tone, then step position and maybe the note
        function int unsigned advance_deck(int d);
            logic [NOTE_W-1:0] n;
            logic [TONE_W-1:0] tone;
            logic [DUR_W-1:0]  dur;
            int unsigned       nxt;
            n    = note[d];
            tone = track_tone[d][n];
            dur  = track_dur[d][n];
            position[d] = position[d] + POS_W'(speed[d]);
            if (position[d] > POS_W'(dur)) begin
                nxt = n + 1;
                if (nxt >= deck_len[d]) nxt = 0;
                note[d]     = NOTE_W'(nxt);
                position[d] = '0;
            end
            return tone;
        endfunction

        function void take_item(mixer_item_t it);
            int unsigned phase;
            int unsigned mix;
            int unsigned w_one;
            int unsigned w_two;
            mix_out_t    res;
            if (it.op == OP_LOAD) begin
                track_tone[it.load_deck][it.load_index] = it.load_tone;
                track_dur[it.load_deck][it.load_index]  = it.load_duration;
                return;
            end
            if (halted) return;
            if (tick_count == POLL_COUNT) begin
                if (it.escape_button) begin
                    halted = 1'b1;
                    return;
                end
                if (it.play_one_button) playing[0] = !playing[0];
                if (it.play_two_button) playing[1] = !playing[1];
                tick_count = '0;
            end
            phase = tick_count % SAMPLE_PERIOD;
            if (phase == PHASE_VOLUME) volume_level = volume_divisor(it.volume_knob);
            if (phase == PHASE_FADE) begin
                if (!playing[0])      weight = '0;
                else if (!playing[1]) weight = FULL_WEIGHT;
                else                  weight = FULL_WEIGHT - WEIGHT_W'(it.fade_knob);
            end
            if (phase == PHASE_SPEED_ONE) speed[0] = deck_rate(it.speed_one_knob);
            if (phase == PHASE_SPEED_TWO) speed[1] = deck_rate(it.speed_two_knob);
            tick_count = tick_count + 1'b1;
            w_one = weight;
            w_two = 1024 - w_one;
            mix   = 0;
            if (playing[0]) mix = advance_deck(0) * w_one;
            if (playing[1]) mix = mix + advance_deck(1) * w_two;
            res.tone   = TONE_W'(mix / 1024);
            res.volume = volume_level;
            pending_mixes.push_back(res);
        endfunction

        function void check_mix(logic [TONE_W-1:0] tone, logic [VOL_W-1:0] volume);
            mix_out_t want;
            results_seen++;
            if (pending_mixes.size() == 0) begin
                $error("result tone %0d volume %0d with no tick pending", tone, volume);
                errors++;
                return;
            end
            want = pending_mixes.pop_front();
            if (tone !== want.tone) begin
                $error("tone_out: expected %0d, actual %0d", want.tone, tone);
                errors++;
            end
            if (volume !== want.volume) begin
                $error("volume_out: expected %0d, actual %0d", want.volume, volume);
                errors++;
            end
        endfunction
    endclass

endpackage

### verif/two_deck_tone_sequencer_mixer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// two_deck_tone_sequencer_mixer_tb - self-checking bench of the tone mixer
// Fills both note tracks, then plays thousands of ticks through several track
// length settings, three button polls and a final escape, with random gaps on
// both channels; every result is checked in order against a scoreboard.
// ============================================================================

module two_deck_tone_sequencer_mixer_tb;

    import tdsm_pkg::*;
    import tdsm_tb_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 2000;   // cycles with no transfer at all
    localparam int SETTLE_CYCLES   = 16;     // covers the output pipe and queue
    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 1010;
    localparam int ESCAPE_POLL     = 4;
    localparam int LONG_HOLD       = 150;
    localparam int HOLD_MARKS [2]  = '{400, 4500};

    // track lengths per phase; phase 0 keeps the reset values
    localparam int ONE_LENGTHS [PHASES] = '{1, 256, 5, 0, 17, 256, 2, 1};
    localparam int TWO_LENGTHS [PHASES] = '{1, 3, 256, 511, 1, 256, 9, 128};

    // quantizer thresholds, used to aim knob samples at both sides of a step
    localparam int KNOB_STEPS [13] = '{103, 171, 205, 308, 341, 410, 512,
                                       615, 683, 717, 819, 853, 922};

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    tdsm_in_if  item_ch ();
    tdsm_out_if result_ch ();

    mixer_scoreboard mix_sb;
    int unsigned     ticks_sent = 0;

    two_deck_tone_sequencer_mixer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // short durations keep notes changing; a few longer ones linger
    function automatic logic [DUR_W-1:0] short_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return DUR_W'($urandom_range(0, 3));
        if (r < 97) return DUR_W'($urandom_range(4, 40));
        return DUR_W'($urandom_range(41, 1023));
    endfunction

    // biased toward the quantizer steps and the ends of the knob range
    function automatic logic [KNOB_W-1:0] pick_knob();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            k = KNOB_STEPS[$urandom_range(0, 12)];
            return KNOB_W'(k - $urandom_range(0, 1));
        end
        if (r == 3) return $urandom_range(0, 1) ? '1 : '0;
        return KNOB_W'($urandom_range(0, 1023));
    endfunction

    // knob and button fields of a load are noise the block must ignore
    function automatic mixer_item_t make_load(logic deck, logic [NOTE_W-1:0] slot,
                                              logic [TONE_W-1:0] tone,
                                              logic [DUR_W-1:0] dur);
        mixer_item_t it;
        it                 = '0;
        it.op              = OP_LOAD;
        it.load_deck       = deck;
        it.load_index      = slot;
        it.load_tone       = tone;
        it.load_duration   = dur;
        it.volume_knob     = KNOB_W'($urandom);
        it.speed_one_knob  = KNOB_W'($urandom);
        it.speed_two_knob  = KNOB_W'($urandom);
        it.fade_knob       = KNOB_W'($urandom);
        it.play_one_button = 1'($urandom_range(0, 1));
        it.play_two_button = 1'($urandom_range(0, 1));
        it.escape_button   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // every field at zero or every field at its maximum
    function automatic mixer_item_t extreme_tick(logic high);
        mixer_item_t it;
        it    = high ? '1 : '0;
        it.op = OP_TICK;
        return it;
    endfunction

    // buttons only matter on a poll tick; those follow a fixed plan:
    // stop deck one, swap which deck is stopped, stop both, then escape
    function automatic mixer_item_t random_tick();
        mixer_item_t it;
        int unsigned poll_no;
        it                 = make_load(1'($urandom_range(0, 1)), NOTE_W'($urandom),
                                       TONE_W'($urandom), DUR_W'($urandom));
        it.op              = OP_TICK;
        it.volume_knob     = pick_knob();
        it.speed_one_knob  = pick_knob();
        it.speed_two_knob  = pick_knob();
        it.fade_knob       = pick_knob();
        if (ticks_sent != 0 && ticks_sent % POLL_PERIOD == 0) begin
            poll_no            = ticks_sent / POLL_PERIOD;
            it.escape_button   = (poll_no >= ESCAPE_POLL);
            it.play_one_button = 1'b1;
            it.play_two_button = (poll_no == 2);
        end
        return it;
    endfunction

    // one transfer on the item channel, after a random gap
    task automatic push_item(input mixer_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.op              <= it.op;
        item_ch.load_deck       <= it.load_deck;
        item_ch.load_index      <= it.load_index;
        item_ch.load_tone       <= it.load_tone;
        item_ch.load_duration   <= it.load_duration;
        item_ch.volume_knob     <= it.volume_knob;
        item_ch.speed_one_knob  <= it.speed_one_knob;
        item_ch.speed_two_knob  <= it.speed_two_knob;
        item_ch.fade_knob       <= it.fade_knob;
        item_ch.play_one_button <= it.play_one_button;
        item_ch.play_two_button <= it.play_two_button;
        item_ch.escape_button   <= it.escape_button;
        do @(posedge i_clk); while (!item_ch.ready);
        mix_sb.take_item(it);
        if (it.op == OP_TICK) ticks_sent++;
    endtask

    // stop offering and let every pending result drain; loads give no
    // result, so a further SETTLE_CYCLES wait lets the last of them land too
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (mix_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_length(input t_reg_index r, input logic [LEN_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(r));
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mix_sb.set_length(r, v);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        mix_sb = new();
        item_ch.valid           <= 1'b0;
        item_ch.op              <= OP_TICK;
        item_ch.load_deck       <= 1'b0;
        item_ch.load_index      <= '0;
        item_ch.load_tone       <= '0;
        item_ch.load_duration   <= '0;
        item_ch.volume_knob     <= '0;
        item_ch.speed_one_knob  <= '0;
        item_ch.speed_two_knob  <= '0;
        item_ch.fade_knob       <= '0;
        item_ch.play_one_button <= 1'b0;
        item_ch.play_two_button <= 1'b0;
        item_ch.escape_button   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every slot of both tracks is written before any tick can read it
        for (int d = 0; d < 2; d++)
            for (int s = 0; s < TRACK_DEPTH_DEF; s++)
                push_item(make_load(1'(d), NOTE_W'(s), TONE_W'($urandom),
                                    short_duration()));

        // directed: tone extremes at the first and last slots, deck two at
        // full tone so the widest mix shows up, then all-zero and all-one
        // ticks (escape and buttons high off a poll tick change nothing)
        push_item(make_load(1'b0, 8'd0,   16'h0000, 16'd0));
        push_item(make_load(1'b1, 8'd0,   16'hFFFF, 16'd0));
        push_item(make_load(1'b0, 8'd255, 16'hFFFF, 16'd1));
        push_item(make_load(1'b1, 8'd255, 16'h0000, 16'd2));
        for (int n = 0; n < 18; n++) push_item(extreme_tick(1'(n)));

        // random phases, each with its own pair of track lengths; the
        // escape poll falls inside the last phase
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                settle();
                write_length(REG_DECK_ONE_LENGTH, LEN_W'(ONE_LENGTHS[ph]));
                write_length(REG_DECK_TWO_LENGTH, LEN_W'(TWO_LENGTHS[ph]));
            end
            while (ticks_sent < (ph + 1) * TICKS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0)
                    push_item(make_load(1'($urandom_range(0, 1)), NOTE_W'($urandom),
                                        TONE_W'($urandom), short_duration()));
                else
                    push_item(random_tick());
            end
        end

        // halted now: loads still land, ticks give nothing
        push_item(make_load(1'b0, 8'd9, 16'hFFFF, 16'hFFFF));
        for (int n = 0; n < 4; n++) push_item(random_tick());
        push_item(make_load(1'b1, 8'd77, 16'h5A5A, 16'h8000));
        push_item(random_tick());

        settle();
        if (mix_sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure, with two long holds so the queue
    // fills and the item channel stalls behind it
    // ------------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned holds_done;
        holds_done = 0;
        result_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 8);
            result_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(1, 3);
            if (holds_done < 2 && mix_sb.results_seen >= HOLD_MARKS[holds_done]) begin
                stall = LONG_HOLD;
                holds_done++;
            end
            result_ch.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            mix_sb.check_mix(result_ch.tone_out, result_ch.volume_out);
    end

    // watchdog: too long without any transfer means the block hung
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
